// ----- sv/service_request_duplicate_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Service request duplicate filter: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SERVICE_REQUEST_DUPLICATE_FILTER_MACROS_SVH
`define SERVICE_REQUEST_DUPLICATE_FILTER_MACROS_SVH

// Same-cycle implication.
`define SRDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/srdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdf_pkg
// Types and constants shared by the duplicate filter controller and datapath.
// ----------------------------------------------------------------------------
package srdf_pkg;

  localparam int KEY_W      = 40;
  localparam int HOPS_W     = 8;
  localparam int METRIC_W   = 32;
  localparam int SLOT_W     = 6;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;

  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [METRIC_W-1:0] metric_t;

  typedef struct packed {
    key_t               key;
    logic [HOPS_W-1:0]  hops;
    metric_t            delay;
    metric_t            cost;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture the incoming request, restart the scan
    logic scan;         // issue the next table read, compare the last one
    logic insert;       // write the request at the replace pointer
    logic write_match;  // overwrite the matched entry's metrics
    logic res_load;     // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // the entry read last cycle matches the key
    logic scan_end;  // every filled slot compared, no match
    logic better;    // request beats the matched entry
    logic record;    // request is a record operation
  } status_t;

endpackage

// ----- sv/service_request_duplicate_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_request_duplicate_filter
// Table of seen service requests that drops duplicates and keeps the best copy.
// ----------------------------------------------------------------------------
// Each request transfer carries a key (request id, source node, service index)
// and its hop count, summed delay and summed cost. A check (tuser = 0) drops a
// known request unless it beats the stored copy, in which case the stored
// metrics are replaced and the request passes; unknown requests pass and are
// not stored. A record (tuser = 1) stores an unknown request at a round-robin
// slot, overwriting the oldest, or updates a known entry when better. Better
// means both delay and cost lower, or their exact sum lower. One result
// transfer follows every request. Requests are handled one at a time: the
// table sits in a memory with one read and one write port that is scanned
// one slot per cycle from slot zero up to the number of filled slots, and a
// request that hits stops the scan at its slot. The table needs no clearing
// after reset: a fill count marks the written slots. A result waiting in the
// output register does not hold off the scan of the next request until that
// request's own result is ready.
// ----------------------------------------------------------------------------
module service_request_duplicate_filter #(
  parameter int ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [15:0] request_id, [31:16] source address, [39:32] service number,
  // [47:40] hops, [79:48] delay_sum, [111:80] cost_sum
  input  logic [srdf_pkg::IN_DATA_W-1:0]    s_tdata,
  // [0] op
  input  logic                              s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] discard, [1] found, [2] updated, [8:3] slot, [15:9] zero
  output logic [srdf_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import srdf_pkg::*;

  cmd_t    cmd;
  status_t st;

  logic               res_discard, res_found, res_updated;
  logic [SLOT_W-1:0]  res_slot;
  key_t               in_key;

  // Key packs as {request id, source address, service number}.
  assign in_key = {s_tdata[15:0], s_tdata[31:16], s_tdata[39:32]};

  srdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  srdf_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_op       (s_tuser),
    .in_key      (in_key),
    .in_hops     (s_tdata[47:40]),
    .in_delay    (s_tdata[79:48]),
    .in_cost     (s_tdata[111:80]),
    .res_discard (res_discard),
    .res_found   (res_found),
    .res_updated (res_updated),
    .res_slot    (res_slot)
  );

  // Pad the result to whole bytes.
  assign m_tdata = {{(OUT_DATA_W - SLOT_W - 3){1'b0}}, res_slot,
                    res_updated, res_found, res_discard};

endmodule

// ----- sv/srdf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdf_ctrl
// Sequencer for one request: accept, scan the table, judge, post the result.
// ----------------------------------------------------------------------------
module srdf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  srdf_pkg::status_t st,
  output srdf_pkg::cmd_t    cmd
);
  import srdf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_JUDGE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   res_free;

  assign res_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          state_next = S_JUDGE;
        end else if (st.scan_end && res_free) begin
          cmd.insert   = st.record;
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_JUDGE: begin
        if (res_free) begin
          cmd.write_match = st.better;
          cmd.res_load    = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/srdf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdf_dp
// Request table memory, scan counter, metric compare and result register.
// ----------------------------------------------------------------------------
module srdf_dp #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srdf_pkg::cmd_t                cmd,
  output srdf_pkg::status_t             st,
  input  logic                          in_op,
  input  srdf_pkg::key_t                in_key,
  input  logic [srdf_pkg::HOPS_W-1:0]   in_hops,
  input  srdf_pkg::metric_t             in_delay,
  input  srdf_pkg::metric_t             in_cost,
  output logic                          res_discard,
  output logic                          res_found,
  output logic                          res_updated,
  output logic [srdf_pkg::SLOT_W-1:0]   res_slot
);
  import srdf_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int XW = IW + SLOT_W;

  // Table storage; slots below fill are the valid ones, since inserts
  // run round-robin from slot zero.
  entry_t mem [ENTRIES];
  entry_t rd_data;
  entry_t wr_data;
  logic [IW-1:0] wr_addr;
  logic          wr_en;

  logic          op_q;
  key_t          key_q;
  logic [HOPS_W-1:0] hops_q;
  metric_t       delay_q, cost_q;

  logic [FW-1:0] scan_idx;
  logic [FW-1:0] fill;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] ptr;
  logic          pend;
  logic          issue;

  logic          found;
  logic [IW-1:0] match_idx;
  metric_t       match_delay, match_cost;

  logic [METRIC_W:0] sum_new, sum_old;
  logic [XW-1:0]     match_ext, ptr_ext;

  assign issue = cmd.scan && (scan_idx < fill);

  assign st.hit      = pend && (rd_data.key == key_q);
  assign st.scan_end = !pend && !(scan_idx < fill);
  assign st.record   = (op_q == OP_RECORD);

  assign sum_new   = {1'b0, delay_q} + {1'b0, cost_q};
  assign sum_old   = {1'b0, match_delay} + {1'b0, match_cost};
  assign st.better = ((delay_q < match_delay) && (cost_q < match_cost))
                     || (sum_new < sum_old);

  assign match_ext = {{SLOT_W{1'b0}}, match_idx};
  assign ptr_ext   = {{SLOT_W{1'b0}}, ptr};

  assign wr_en   = cmd.insert || cmd.write_match;
  assign wr_addr = cmd.insert ? ptr : match_idx;
  assign wr_data = '{key: key_q, hops: hops_q, delay: delay_q, cost: cost_q};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[scan_idx[IW-1:0]];
  end

  // Request capture and match metrics
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= in_op;
      key_q   <= in_key;
      hops_q  <= in_hops;
      delay_q <= in_delay;
      cost_q  <= in_cost;
    end
    if (cmd.scan) begin
      rd_idx <= scan_idx[IW-1:0];
    end
    if (cmd.scan && st.hit) begin
      match_idx   <= rd_idx;
      match_delay <= rd_data.delay;
      match_cost  <= rd_data.cost;
    end
    if (cmd.res_load) begin
      res_discard <= found && !st.better && !st.record;
      res_found   <= found;
      res_updated <= found ? st.better : st.record;
      if (found) begin
        res_slot <= match_ext[SLOT_W-1:0];
      end else if (st.record) begin
        res_slot <= ptr_ext[SLOT_W-1:0];
      end else begin
        res_slot <= '0;
      end
    end
  end

  // Scan and fill control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      fill     <= '0;
      ptr      <= '0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        pend     <= 1'b0;
        found    <= 1'b0;
      end else if (cmd.scan) begin
        pend <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (st.hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.insert) begin
        ptr <= (ptr == IW'(ENTRIES - 1)) ? '0 : ptr + 1'b1;
        if (fill != FW'(ENTRIES)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/srdf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdf_checker
// Port-level checks on the duplicate filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "service_request_duplicate_filter_macros.svh"

module srdf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [srdf_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import srdf_pkg::*;

  // A stalled result holds.
  `SRDF_ASSERT_NEXT(a_res_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Only a known request is dropped, and a dropped one never writes.
  `SRDF_ASSERT_SAME(a_discard_known, m_tvalid && m_tdata[0], m_tdata[1] && !m_tdata[2], "discard without a stored match")

  // A check that misses reports slot zero.
  `SRDF_ASSERT_SAME(a_miss_slot, m_tvalid && !m_tdata[1] && !m_tdata[2], m_tdata[8:3] == '0, "miss reported a nonzero slot")

  // A taken request moves the sequencer out of idle, so requests never follow back to back.
  `SRDF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken during a scan")

endmodule

bind service_request_duplicate_filter srdf_checker u_srdf_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the service request duplicate filter.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and verdicts come back on the master
// stream, one per request. A behavioral copy of the request table ranks each
// accepted request against its stored copy and queues the verdict it should
// produce. A checker process compares each returned verdict field by field
// with the oldest queued one. Directed tests cover empty-table misses, every
// ranking outcome (better on both metrics, better on the exact 33-bit sum,
// worse, undecided, ties), and keys that differ in a single field. Random
// traffic then runs phases with key pools smaller and larger than the table,
// so both repeated hits and round-robin eviction get exercised. A final test
// holds the result stream off long enough to stall the request stream.
// ----------------------------------------------------------------------------
module tb;

  import srdf_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int LONG_HOLD   = 400;   // receiver hold-off in the pressure test
  localparam int POOL_SIZE   = 96;

  typedef enum logic [1:0] {RANK_WORSE, RANK_UNDECIDED, RANK_BETTER} rank_t;

  typedef struct packed {
    logic        op;
    logic [15:0] request_id;
    logic [15:0] src_addr;
    logic [7:0]  svc_idx;
    logic [7:0]  hops;
    metric_t     delay;
    metric_t     cost;
  } request_t;

  typedef struct packed {
    logic       discard;
    logic       found;
    logic       updated;
    logic [5:0] slot;
  } verdict_t;

  logic                    clk      = 1'b0;
  logic                    rst      = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata  = '0;
  logic                    s_tuser  = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;

  // Behavioral copy of the request table
  bit       tab_valid [ENTRIES];
  key_t     tab_key   [ENTRIES];
  logic [7:0] tab_hops [ENTRIES];
  metric_t  tab_delay [ENTRIES];
  metric_t  tab_cost  [ENTRIES];
  int       victim = 0;

  verdict_t verdict_q[$];
  key_t     key_pool[POOL_SIZE];

  int  mismatch_count  = 0;
  int  idle_cycles     = 0;
  int  hold_request    = 0;   // one-shot long hold-off for the receiver
  bit  sender_idle_on  = 1'b1;
  bit  receiver_idle_on = 1'b1;

  always #5 clk = ~clk;

  service_request_duplicate_filter #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Lowest valid slot holding the key, -1 on a miss.
  function automatic int find_entry(key_t k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tab_valid[i] && tab_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic rank_t rank_metrics(metric_t d, metric_t c, metric_t sd, metric_t sc);
    logic [32:0] sum_new;
    logic [32:0] sum_old;
    sum_new = {1'b0, d} + {1'b0, c};
    sum_old = {1'b0, sd} + {1'b0, sc};
    if (d < sd && c < sc) return RANK_BETTER;
    if (sum_new < sum_old) return RANK_BETTER;
    if (d > sd && c > sc) return RANK_WORSE;
    return RANK_UNDECIDED;
  endfunction

  // Apply one accepted request to the table copy and return its verdict.
  function automatic verdict_t predict_verdict(request_t r);
    verdict_t v;
    key_t     k;
    int       hit;
    v   = '0;
    k   = {r.request_id, r.src_addr, r.svc_idx};
    hit = find_entry(k);
    if (hit >= 0) begin
      v.found = 1'b1;
      v.slot  = hit[5:0];
      if (rank_metrics(r.delay, r.cost, tab_delay[hit], tab_cost[hit]) == RANK_BETTER) begin
        tab_hops[hit]  = r.hops;
        tab_delay[hit] = r.delay;
        tab_cost[hit]  = r.cost;
        v.updated      = 1'b1;
      end else if (r.op == OP_CHECK) begin
        v.discard = 1'b1;
      end
    end else if (r.op == OP_RECORD) begin
      // overwrite the oldest slot and advance the round-robin pointer
      tab_valid[victim] = 1'b1;
      tab_key[victim]   = k;
      tab_hops[victim]  = r.hops;
      tab_delay[victim] = r.delay;
      tab_cost[victim]  = r.cost;
      v.updated         = 1'b1;
      v.slot            = victim[5:0];
      victim            = (victim + 1) % ENTRIES;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic request_t make_request(logic op, key_t k, logic [7:0] hops,
                                            metric_t d, metric_t c);
    request_t r;
    r.op         = op;
    r.request_id = k[39:24];
    r.src_addr   = k[23:8];
    r.svc_idx    = k[7:0];
    r.hops       = hops;
    r.delay      = d;
    r.cost       = c;
    return r;
  endfunction

  function automatic key_t make_key(logic [15:0] rid, logic [15:0] src, logic [7:0] svc);
    return {rid, src, svc};
  endfunction

  function automatic metric_t boundary_metric();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFE;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Metrics close to a stored copy give ties and near-misses on both rules.
  function automatic request_t random_request(int pool_size, int record_pct);
    key_t    k;
    metric_t d;
    metric_t c;
    int      hit;
    int      mode;
    logic    op;
    if ($urandom_range(0, 9) == 0) k = key_t'({$urandom(), $urandom()});
    else k = key_pool[$urandom_range(0, pool_size - 1)];
    op   = ($urandom_range(0, 99) < record_pct) ? OP_RECORD : OP_CHECK;
    hit  = find_entry(k);
    mode = $urandom_range(0, 9);
    if (hit >= 0 && mode < 4) begin
      d = tab_delay[hit] + $urandom_range(0, 4) - 32'd2;
      c = tab_cost[hit] + $urandom_range(0, 4) - 32'd2;
    end else if (mode < 6) begin
      d = $urandom_range(0, 7);
      c = $urandom_range(0, 7);
    end else if (mode < 8) begin
      d = boundary_metric();
      c = boundary_metric();
    end else begin
      d = $urandom();
      c = $urandom();
    end
    return make_request(op, k, 8'($urandom_range(0, 255)), d, c);
  endfunction

  // Offer one request and hold it until the transfer; valid stays high into
  // the next request when no gap is drawn.
  task automatic send_request(input request_t r);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {r.cost, r.delay, r.hops, r.svc_idx, r.src_addr, r.request_id};
    do @(posedge clk); while (!s_tready);
    verdict_q.push_back(predict_verdict(r));
  endtask

  task automatic report_mismatch(string what, longint unsigned expv, longint unsigned gotv);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, expv, gotv);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: draw a hold-off per result, then compare with the oldest
  // expected verdict.
  // --------------------------------------------------------------------------
  initial begin : result_checker
    int       gap;
    verdict_t exp_v;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = receiver_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", 0, m_tdata);
      end else begin
        exp_v = verdict_q.pop_front();
        if (m_tdata[0] !== exp_v.discard) report_mismatch("discard", exp_v.discard, m_tdata[0]);
        if (m_tdata[1] !== exp_v.found)   report_mismatch("found", exp_v.found, m_tdata[1]);
        if (m_tdata[2] !== exp_v.updated) report_mismatch("updated", exp_v.updated, m_tdata[2]);
        if (m_tdata[8:3] !== exp_v.slot)  report_mismatch("slot", exp_v.slot, m_tdata[8:3]);
        if (m_tdata[15:9] !== 7'd0)       report_mismatch("pad bits", 0, m_tdata[15:9]);
      end
    end
  end

  // Watchdog: end the run when neither stream moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Lookup on an empty table misses; all fields at their upper extremes.
  task automatic test_empty_table();
    send_request(make_request(OP_CHECK, make_key(16'hFFFF, 16'hFFFF, 8'hFF), 8'hFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // Walk two keys through every ranking outcome on both operations.
  task automatic test_metric_ranking();
    key_t k_low;
    key_t k_high;
    k_low  = make_key(16'h0000, 16'h0000, 8'h00);
    k_high = make_key(16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(make_request(OP_RECORD, k_low, 8'h00, 32'd100, 32'd100));
    send_request(make_request(OP_RECORD, k_high, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_CHECK, k_low, 8'h01, 32'd100, 32'd100));   // tie
    send_request(make_request(OP_CHECK, k_low, 8'h02, 32'd101, 32'd101));   // worse
    send_request(make_request(OP_CHECK, k_low, 8'h03, 32'd50, 32'd200));    // undecided
    send_request(make_request(OP_CHECK, k_low, 8'h04, 32'd150, 32'd40));    // lower sum
    send_request(make_request(OP_CHECK, k_low, 8'h05, 32'd149, 32'd39));    // both lower
    send_request(make_request(OP_RECORD, k_low, 8'h06, 32'd149, 32'd39));   // known, tie
    send_request(make_request(OP_RECORD, k_low, 8'h07, 32'hFFFF_FFFF, 32'd0));
    send_request(make_request(OP_RECORD, k_low, 8'h08, 32'd0, 32'd0));      // better
    // sum rule must use the carry out of the 32-bit add
    send_request(make_request(OP_CHECK, k_high, 8'h09, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
    send_request(make_request(OP_CHECK, k_high, 8'h0A, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_RECORD, k_high, 8'h0B, 32'd0, 32'hFFFF_FFFF));
    send_request(make_request(OP_CHECK, k_low, 8'h0C, 32'd1, 32'd0));
  endtask

  // Keys that differ from a stored one in a single field must miss.
  task automatic test_key_fields();
    send_request(make_request(OP_CHECK, make_key(16'h0000, 16'h0000, 8'h01), 8'h10, 32'd0, 32'd0));
    send_request(make_request(OP_CHECK, make_key(16'h0000, 16'h0001, 8'h00), 8'h11, 32'd0, 32'd0));
    send_request(make_request(OP_CHECK, make_key(16'h0001, 16'h0000, 8'h00), 8'h12, 32'd0, 32'd0));
    send_request(make_request(OP_RECORD, make_key(16'h0000, 16'h0000, 8'hFF), 8'h13, 32'd5, 32'd5));
  endtask

  // Phases with small pools hammer repeated hits; pools larger than the table
  // force the replace pointer to wrap and evict live entries.
  task automatic test_random_traffic();
    int pool_sizes[7] = '{4, 96, 16, 96, 8, 96, 64};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = key_t'({$urandom(), $urandom()});
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int ph = 0; ph < 7; ph++) begin
      sender_idle_on   = (ph == 0) ? 1'b0 : $urandom_range(0, 3) != 0;
      receiver_idle_on = (ph == 0) ? 1'b0 : $urandom_range(0, 3) != 0;
      for (int n = 0; n < 100; n++) begin
        send_request(random_request(pool_sizes[ph], (ph == 1) ? 80 : 50));
      end
    end
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
  endtask

  // Hold the result stream off while requests keep coming, so the block
  // backs up and drops s_tready.
  task automatic test_result_backpressure();
    sender_idle_on = 1'b0;
    hold_request   = LONG_HOLD;
    for (int n = 0; n < 8; n++) send_request(random_request(16, 50));
    sender_idle_on = 1'b1;
  endtask

  initial begin : main
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_metric_ranking();
    test_key_fields();
    test_random_traffic();
    test_result_backpressure();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/srdf_pkg.sv
sv/srdf_ctrl.sv
sv/srdf_dp.sv
sv/service_request_duplicate_filter.sv
sv/srdf_checker.sv
tb/tb.sv
